/* design/irsac_pkg.sv */
package irsac_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int SENSORS    = 5;
  localparam int LEVEL_W    = 13;
  localparam int CHANGE_W   = 14;
  localparam int MV_W       = 14;
  localparam int LED_W      = 3;
  localparam int CH_W       = 3;
  localparam int CFG_W      = 5;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 64;

  localparam logic [CFG_W-1:0] LAG_RESET = 5'd11;

  // one result slot handed from the scan sequencer to the history and math stages
  typedef struct packed {
    logic               frame;
    logic               last;
    logic [CH_W-1:0]    ch;
    logic [LED_W-1:0]   led;
    logic [MV_W-1:0]    mv;
    logic [LEVEL_W-1:0] level;
  } beat_t;

  // history values for the channel in flight, already masked for unfilled entries
  typedef struct packed {
    logic [LEVEL_W-1:0] lag_level;
    logic [LEVEL_W-1:0] h0;
    logic [LEVEL_W-1:0] h1;
  } hist_t;

endpackage

/* design/ir_sensor_ambient_cancel_sequencer_unit.sv */
// Ambient-cancelling IR reflectance scan sequencer. Each input word is one finished ADC scan
// (battery plus five sensor samples). A phase counter steps one scan at a time: it lights
// emitter k+1 after phase k, captures lit samples in phases 1..CHANNELS and dark samples at
// frame end, where each channel's lit-minus-dark level goes into a per-channel history kept
// in a block memory, together with a small memory of the two newest levels for the mean.
// A scan that does not end a frame yields one word; a frame-end scan yields CHANNELS words,
// one per cycle while the output is not stalled, since each channel takes one read of the
// history memory. The next scan is taken in the cycle its predecessor issues its last word.
// An issued word is held in the r stage register and then in the m stage register, which
// drives the output. No clearing pass after reset: a fill count masks unwritten history as
// zero, so the block is ready as soon as reset is released.
module ir_sensor_ambient_cancel_sequencer_unit #(
  parameter int CHANNELS      = 5,
  parameter int HISTORY_DEPTH = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [irsac_pkg::CFG_W-1:0]       cfg_data,    // change_lag
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // battery_sample[11:0], sensor_sample_0..4 in 12-bit steps from bit 12 up
  input  logic [irsac_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // led_drive[2:0], battery_mv[16:3], channel[19:17], level[32:20], change[46:33],
  // mean[59:47], zero pad above
  output logic [irsac_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                              out_tuser,   // channel_valid
  output logic                              out_tlast
);
  import irsac_pkg::*;

  localparam int SW = $clog2(HISTORY_DEPTH);

  logic [SW-1:0]  lag_r;
  logic           issue;
  logic           r_ready;
  beat_t          beat;
  hist_t          hist;

  assign cfg_ready = 1'b1;

  // lags at or beyond the history depth clamp to the oldest entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lag_r <= SW'(LAG_RESET);
    end else if (cfg_valid && cfg_ready) begin
      if ({1'b0, cfg_data} >= (CFG_W+1)'(HISTORY_DEPTH)) begin
        lag_r <= SW'(HISTORY_DEPTH - 1);
      end else begin
        lag_r <= SW'(cfg_data);
      end
    end
  end

  irsac_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .r_ready   (r_ready),
    .issue     (issue),
    .beat      (beat)
  );

  irsac_store #(
    .CHANNELS      (CHANNELS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .lag   (lag_r),
    .issue (issue),
    .beat  (beat),
    .hist  (hist)
  );

  irsac_calc u_calc (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (issue),
    .beat       (beat),
    .r_ready    (r_ready),
    .hist       (hist),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* design/irsac_front.sv */
module irsac_front #(
  parameter int CHANNELS = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [irsac_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                             r_ready,
  output logic                             issue,
  output irsac_pkg::beat_t                 beat
);
  import irsac_pkg::*;

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW = $clog2(CHANNELS + 2);
  localparam logic [PW-1:0] PH_END   = PW'(CHANNELS + 1);
  localparam logic [PW-1:0] PH_LIT   = PW'(CHANNELS);
  localparam logic [CW-1:0] CH_LAST  = CW'(CHANNELS - 1);
  localparam int PROD_W = SAMPLE_W + MV_W;
  localparam logic [MV_W-1:0] MV_SCALE = 14'd9900;
  localparam logic [MV_W:0] ADC_FULL1 = 15'd4095;
  localparam logic [MV_W:0] ADC_FULL2 = 15'd8190;
  localparam logic [MV_W:0] ADC_FULL3 = 15'd12285;

  // floor(y / 4095): y = q0*4095 + (lo + q0), remainder below 4*4095
  function automatic logic [MV_W-1:0] batt_mv(input logic [PROD_W-1:0] y);
    logic [MV_W-1:0] q0;
    logic [MV_W:0]   rem;
    q0  = y[PROD_W-1:SAMPLE_W];
    rem = {3'b000, y[SAMPLE_W-1:0]} + {1'b0, q0};
    return q0 + MV_W'(rem >= ADC_FULL1) + MV_W'(rem >= ADC_FULL2) + MV_W'(rem >= ADC_FULL3);
  endfunction

  logic [PW-1:0]       phase_r, phase_nxt, ph;
  logic [SAMPLE_W-1:0] sens [CHANNELS];
  logic [SAMPLE_W-1:0] lit_r [CHANNELS];
  logic [SAMPLE_W-1:0] dark_r [CHANNELS];
  logic                job_valid_r;
  logic                job_frame_r;
  logic [CW-1:0]       job_ch_r;
  logic [LED_W-1:0]    job_led_r;
  logic [PROD_W-1:0]   job_y_r;
  logic                accept;
  logic                frame_end;
  logic                last_beat;
  logic [LED_W-1:0]    led_nxt;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_sens
    if (c < SENSORS) begin : g_in
      assign sens[c] = in_tdata[SAMPLE_W*(c+1) +: SAMPLE_W];
    end else begin : g_zero
      assign sens[c] = '0;
    end
  end

  assign ph        = (phase_r > PH_END) ? '0 : phase_r;
  assign frame_end = (ph == PH_END);
  assign phase_nxt = frame_end ? '0 : ph + 1'b1;
  assign led_nxt   = (ph < PH_LIT) ? LED_W'(ph) + 1'b1 : '0;

  assign last_beat = !job_frame_r || (job_ch_r == CH_LAST);
  assign issue     = job_valid_r && r_ready;
  assign in_tready = !job_valid_r || (issue && last_beat);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    beat.frame = job_frame_r;
    beat.last  = last_beat;
    beat.ch    = job_frame_r ? CH_W'(job_ch_r) : '0;
    beat.led   = job_led_r;
    beat.mv    = batt_mv(job_y_r);
    beat.level = job_frame_r ? ({1'b0, lit_r[job_ch_r]} - {1'b0, dark_r[job_ch_r]}) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      job_valid_r <= 1'b0;
      job_ch_r    <= '0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        job_valid_r <= 1'b1;
        job_ch_r    <= '0;
      end else if (issue) begin
        if (last_beat) begin
          job_valid_r <= 1'b0;
        end else begin
          job_ch_r <= job_ch_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_frame_r <= frame_end;
      job_led_r   <= led_nxt;
      job_y_r     <= PROD_W'(in_tdata[SAMPLE_W-1:0]) * PROD_W'(MV_SCALE);
      for (int c = 0; c < CHANNELS; c++) begin
        dark_r[c] <= sens[c];
        // emitter c+1 was lit during the scan of phase c+1
        if (ph == PW'(c + 1)) begin
          lit_r[c] <= sens[c];
        end
      end
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_END) else $error("phase counter out of range");

  a_ch_step: assert property (@(posedge clk) disable iff (!rst_n)
    issue && !last_beat |=> job_valid_r && (job_ch_r == $past(job_ch_r) + 1'b1))
    else $error("channel sequence skipped or stopped");

  a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r && !job_frame_r |-> job_ch_r == '0)
    else $error("non frame scan past its first word");

endmodule

/* design/irsac_store.sv */
module irsac_store #(
  parameter int CHANNELS      = 5,
  parameter int HISTORY_DEPTH = 20
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [$clog2(HISTORY_DEPTH)-1:0]     lag,
  input  logic                                 issue,
  input  irsac_pkg::beat_t                     beat,
  output irsac_pkg::hist_t                     hist
);
  import irsac_pkg::*;

  localparam int CW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW      = $clog2(HISTORY_DEPTH);
  localparam int NW      = $clog2(HISTORY_DEPTH + 1);
  localparam int DEPTH_A = CHANNELS * HISTORY_DEPTH;
  localparam int AW      = $clog2(DEPTH_A);

  logic [LEVEL_W-1:0]   hist_mem [DEPTH_A];
  logic [2*LEVEL_W-1:0] recent_mem [CHANNELS];   // {newest, second newest}

  logic [SW-1:0]        slot_r;
  logic [NW-1:0]        fill_r;
  logic [SW-1:0]        slot_new;
  logic [SW:0]          lag_slot_w;
  logic [CW-1:0]        ch;
  logic [AW-1:0]        base, rd_addr, wr_addr;
  logic                 rd_en;

  logic [LEVEL_W-1:0]   lag_q;
  logic [2*LEVEL_W-1:0] rec_q;
  logic [LEVEL_W-1:0]   lvl_q;
  logic                 lag_zero_q, lag_ok_q, h0_ok_q, h1_ok_q;
  logic                 rec_wr_r;
  logic [CW-1:0]        rec_ch_r;

  assign rd_en    = issue && beat.frame;
  assign ch       = beat.ch[CW-1:0];
  assign slot_new = ({1'b0, slot_r} == (SW+1)'(HISTORY_DEPTH - 1)) ? '0 : slot_r + 1'b1;
  // slot of the entry lag frames older than the one being pushed
  assign lag_slot_w = ({1'b0, slot_new} >= {1'b0, lag}) ?
                      {1'b0, slot_new} - {1'b0, lag} :
                      {1'b0, slot_new} + (SW+1)'(HISTORY_DEPTH) - {1'b0, lag};
  assign base     = AW'(ch) * AW'(HISTORY_DEPTH);
  assign rd_addr  = base + AW'(lag_slot_w[SW-1:0]);
  assign wr_addr  = base + AW'(slot_new);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      hist_mem[wr_addr] <= beat.level;
      lag_q             <= hist_mem[rd_addr];
      rec_q             <= recent_mem[ch];
      lvl_q             <= beat.level;
      rec_ch_r          <= ch;
      lag_zero_q        <= (lag == '0);
      lag_ok_q          <= (NW'(lag) <= fill_r);
      h0_ok_q           <= (fill_r != '0);
      h1_ok_q           <= (fill_r >= NW'(2));
    end
    // newest pair written back once the old newest is out of the memory
    if (rec_wr_r) begin
      recent_mem[rec_ch_r] <= {lvl_q, rec_q[2*LEVEL_W-1:LEVEL_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= '0;
      fill_r   <= '0;
      rec_wr_r <= 1'b0;
    end else begin
      rec_wr_r <= rd_en;
      if (rd_en && beat.last) begin
        slot_r <= slot_new;
        if (fill_r != NW'(HISTORY_DEPTH)) begin
          fill_r <= fill_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    hist.lag_level = lag_zero_q ? lvl_q : (lag_ok_q ? lag_q : '0);
    hist.h0        = h0_ok_q ? rec_q[2*LEVEL_W-1:LEVEL_W] : '0;
    hist.h1        = h1_ok_q ? rec_q[LEVEL_W-1:0] : '0;
  end

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, slot_r} < (SW+1)'(HISTORY_DEPTH)) else $error("history slot out of range");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= NW'(HISTORY_DEPTH)) else $error("fill count beyond depth");

  a_lag_apart: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en && (lag != '0) |-> rd_addr != wr_addr)
    else $error("lag read hits the entry being pushed");

endmodule

/* design/irsac_calc.sv */
module irsac_calc (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              issue,
  input  irsac_pkg::beat_t                  beat,
  output logic                              r_ready,
  input  irsac_pkg::hist_t                  hist,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [irsac_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                              out_tuser,
  output logic                              out_tlast
);
  import irsac_pkg::*;

  localparam int SUM_W  = LEVEL_W + 2;
  localparam int MAG_W  = LEVEL_W + 1;
  localparam int RCP_W  = 16;
  localparam int RPW    = MAG_W + RCP_W;
  localparam int RCP_SH = 17;
  localparam logic [RCP_W-1:0] RECIP3 = 16'd43691;   // ceil(2^17 / 3)
  localparam int PAD_W  = OUT_DATA_W - (LED_W + MV_W + CH_W + LEVEL_W + CHANGE_W + LEVEL_W);

  logic               r_valid_r;
  beat_t              r_beat_r;
  logic               m_valid_r;
  logic               m_ready;
  logic [LED_W-1:0]   m_led_r;
  logic [MV_W-1:0]    m_mv_r;
  logic               m_chv_r;
  logic [CH_W-1:0]    m_ch_r;
  logic [LEVEL_W-1:0] m_level_r;
  logic [CHANGE_W-1:0] m_change_r;
  logic [RPW-1:0]     m_prod_r;
  logic               m_neg_r;
  logic               m_last_r;

  logic [LEVEL_W-1:0] lvl;
  logic [CHANGE_W-1:0] change;
  logic [SUM_W-1:0]   sum, sum_neg;
  logic               neg;
  logic [MAG_W-1:0]   mag;
  logic [LEVEL_W-1:0] quo, mean;

  assign m_ready = !m_valid_r || out_tready;
  assign r_ready = !r_valid_r || m_ready;

  assign lvl     = r_beat_r.level;
  assign change  = {lvl[LEVEL_W-1], lvl} -
                   {hist.lag_level[LEVEL_W-1], hist.lag_level};
  assign sum     = {{2{lvl[LEVEL_W-1]}}, lvl} +
                   {{2{hist.h0[LEVEL_W-1]}}, hist.h0} +
                   {{2{hist.h1[LEVEL_W-1]}}, hist.h1};
  assign neg     = sum[SUM_W-1];
  assign sum_neg = -sum;
  assign mag     = neg ? sum_neg[MAG_W-1:0] : sum[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_valid_r <= 1'b0;
      m_valid_r <= 1'b0;
    end else begin
      if (r_ready) begin
        r_valid_r <= issue;
      end
      if (m_ready) begin
        m_valid_r <= r_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue && r_ready) begin
      r_beat_r <= beat;
    end
    if (r_valid_r && m_ready) begin
      m_led_r  <= r_beat_r.led;
      m_mv_r   <= r_beat_r.mv;
      m_last_r <= r_beat_r.last;
      m_chv_r  <= r_beat_r.frame;
      m_ch_r   <= r_beat_r.ch;
      if (r_beat_r.frame) begin
        m_level_r  <= lvl;
        m_change_r <= change;
        m_prod_r   <= RPW'(mag) * RPW'(RECIP3);
        m_neg_r    <= neg;
      end else begin
        m_level_r  <= '0;
        m_change_r <= '0;
        m_prod_r   <= '0;
        m_neg_r    <= 1'b0;
      end
    end
  end

  // truncation toward zero: divide the magnitude, then restore the sign
  assign quo  = m_prod_r[RPW-1:RCP_SH];
  assign mean = m_neg_r ? -quo : quo;

  assign out_tvalid = m_valid_r;
  assign out_tuser  = m_chv_r;
  assign out_tlast  = m_last_r;
  assign out_tdata  = {{PAD_W{1'b0}}, mean, m_change_r, m_level_r, m_ch_r, m_mv_r, m_led_r};

endmodule

/* tb/ir_sensor_ambient_cancel_sequencer_unit_tb.sv */
module ir_sensor_ambient_cancel_sequencer_unit_tb;
  import irsac_pkg::*;

  localparam int DEPTH = 20;
  localparam int DARK_PHASE = SENSORS + 1;
  localparam int QUIET_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [LED_W-1:0]    led;
    logic [MV_W-1:0]     mv;
    logic                valid;
    logic [CH_W-1:0]     ch;
    logic [LEVEL_W-1:0]  level;
    logic [CHANGE_W-1:0] change;
    logic [LEVEL_W-1:0]  mean;
    logic                last;
  } scan_word_t;

  class scan_scoreboard;
    int scan_phase;
    int lag;
    logic [SAMPLE_W-1:0] lit [SENSORS];
    logic signed [LEVEL_W-1:0] hist [SENSORS*DEPTH];
    scan_word_t due [$];
    int errors;

    function new();
      scan_phase = 0;
      lag = int'(LAG_RESET);
      errors = 0;
      foreach (lit[i]) lit[i] = '0;
      foreach (hist[i]) hist[i] = '0;
    endfunction

    function void set_lag(logic [CFG_W-1:0] v);
      lag = int'(v);
    endfunction

    function int pending();
      return due.size();
    endfunction

    // work out the words one accepted scan causes
    function void note_scan(logic [IN_DATA_W-1:0] d);
      int bat, mv, p, c, j, eff, lvl, chg, avg, dark;
      scan_word_t w;
      bat = int'(d[SAMPLE_W-1:0]);
      mv = bat * 9900 / 4095;
      p = scan_phase;
      if (p > DARK_PHASE) p = 0;
      w = '0;
      w.led = LED_W'((p < SENSORS) ? p + 1 : 0);
      w.mv = MV_W'(mv);
      if (p >= 1 && p <= SENSORS) lit[p-1] = d[SAMPLE_W*p +: SAMPLE_W];
      if (p != DARK_PHASE) begin
        scan_phase = p + 1;
        w.last = 1'b1;
        due.push_back(w);
        return;
      end
      scan_phase = 0;
      eff = (lag >= DEPTH) ? DEPTH - 1 : lag;
      for (c = 0; c < SENSORS; c++) begin
        for (j = DEPTH - 1; j >= 1; j--) hist[c*DEPTH+j] = hist[c*DEPTH+j-1];
        dark = int'(d[SAMPLE_W*(c+1) +: SAMPLE_W]);
        lvl = int'(lit[c]) - dark;
        hist[c*DEPTH] = LEVEL_W'(lvl);
        chg = lvl - int'(hist[c*DEPTH+eff]);
        avg = (int'(hist[c*DEPTH]) + int'(hist[c*DEPTH+1]) + int'(hist[c*DEPTH+2])) / 3;
        w.valid = 1'b1;
        w.ch = CH_W'(c);
        w.level = LEVEL_W'(lvl);
        w.change = CHANGE_W'(chg);
        w.mean = LEVEL_W'(avg);
        w.last = (c == SENSORS - 1);
        due.push_back(w);
      end
    endfunction

    function void cmp(string field, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $error("%s expected %0d actual %0d", field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_word(logic [OUT_DATA_W-1:0] td, logic tu, logic tl);
      scan_word_t e;
      if (due.size() == 0) begin
        $error("word with no expectation waiting: tdata %h", td);
        errors++;
        return;
      end
      e = due.pop_front();
      cmp("led_drive", e.led, td[2:0]);
      cmp("battery_mv", e.mv, td[16:3]);
      cmp("channel_valid", e.valid, tu);
      cmp("channel", e.ch, td[19:17]);
      cmp("level", $signed(e.level), $signed(td[32:20]));
      cmp("change", $signed(e.change), $signed(td[46:33]));
      cmp("mean", $signed(e.mean), $signed(td[59:47]));
      cmp("last", e.last, tl);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  scan_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet;

  ir_sensor_ambient_cancel_sequencer_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata, out_tuser, out_tlast);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("ir_sensor_ambient_cancel_sequencer_unit verification failed");
      $finish;
    end
  end

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom_range(4095));
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_scan(input logic [SAMPLE_W-1:0] bat, input logic [5*SAMPLE_W-1:0] sens);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {sens, bat};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_scan({sens, bat});
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [5*SAMPLE_W-1:0] lit_v, input logic [5*SAMPLE_W-1:0] dark_v);
    int k;
    send_scan('0, '0);
    for (k = 0; k < SENSORS; k++) send_scan('1, lit_v);
    send_scan(12'd2048, dark_v);
  endtask

  // let the pipe empty before touching the register
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_lag(input logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_lag(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] lag_v, input int snd, input int rcv,
                           input int n);
    int i, c;
    logic [5*SAMPLE_W-1:0] sens;
    settle();
    write_lag(lag_v);
    send_idle_pct = snd;
    recv_stall_pct = rcv;
    for (i = 0; i < n; i++) begin
      for (c = 0; c < SENSORS; c++) sens[SAMPLE_W*c +: SAMPLE_W] = rand_sample();
      send_scan(rand_sample(), sens);
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed frames under the reset lag: full-scale positive, full-scale negative, small mixed
    send_frame({5{12'hFFF}}, '0);
    send_frame('0, {5{12'hFFF}});
    send_frame({12'd4095, 12'd0, 12'd2, 12'd0, 12'd1},
               {12'd0, 12'd2, 12'd0, 12'd1, 12'd0});

    run_phase(5'd1, 0, 0, 28);
    run_phase(5'd19, 68, 0, 28);
    run_phase(5'd0, 0, 68, 28);
    run_phase(5'd31, 37, 37, 28);
    run_phase(5'd20, 68, 0, 24);
    run_phase(5'd7, 0, 68, 24);

    settle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("ir_sensor_ambient_cancel_sequencer_unit verification clean");
    else
      $display("ir_sensor_ambient_cancel_sequencer_unit verification failed");
    $finish;
  end

endmodule
